FILE: hw/rtl/tmlc_pkg.sv
// ----------------------------------------------------------------------------
// tmlc_pkg
// Types, codes and defaults shared by the tray motor limit controller.
// ----------------------------------------------------------------------------
package tmlc_pkg;

   localparam int DELAY_BITS_DEFAULT = 16;
   localparam int CFG_BITS           = 16;
   localparam int CSR_INDEX_BITS     = 1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OPEN_OVERRUN  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLOSE_OVERRUN = 1'd1;

   // requested target codes
   localparam logic [1:0] REQ_OFF    = 2'd0;
   localparam logic [1:0] REQ_OPEN   = 2'd1;
   localparam logic [1:0] REQ_CLOSED = 2'd2;

   // controller mode codes
   localparam logic [1:0] MODE_OFF     = 2'd0;
   localparam logic [1:0] MODE_OPENING = 2'd1;
   localparam logic [1:0] MODE_CLOSING = 2'd2;

   // motor bridge codes
   localparam logic [1:0] DRIVE_OFF   = 2'd0;
   localparam logic [1:0] DRIVE_OPEN  = 2'd1;
   localparam logic [1:0] DRIVE_CLOSE = 2'd2;

   // reported position codes
   localparam logic [2:0] POS_OFF     = 3'd0;
   localparam logic [2:0] POS_CLOSED  = 3'd1;
   localparam logic [2:0] POS_OPEN    = 3'd2;
   localparam logic [2:0] POS_OPENING = 3'd3;
   localparam logic [2:0] POS_CLOSING = 3'd4;

   typedef struct packed {
      logic       closed_sensor_level;
      logic       open_sensor_level;
      logic [1:0] requested_state;
   } req_type;

   typedef struct packed {
      logic [1:0] motor_drive;
      logic [2:0] tray_position;
      logic [1:0] controller_mode;
   } rsp_type;

endpackage

FILE: hw/rtl/tmlc_core.sv
// ----------------------------------------------------------------------------
// tmlc_core
// Mode tracking, motor drive and overrun timer for one tick per step.
// ----------------------------------------------------------------------------
module tmlc_core import tmlc_pkg::*; #(
   parameter int DELAY_BITS = DELAY_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  req_type             item,
   input  logic [CFG_BITS-1:0] open_delay,
   input  logic [CFG_BITS-1:0] close_delay,
   output rsp_type             result
);

   localparam int CMP_BITS = (DELAY_BITS > CFG_BITS) ? DELAY_BITS : CFG_BITS;
   localparam logic [DELAY_BITS-1:0] COUNT_MAX = {DELAY_BITS{1'b1}};

   logic [1:0]            mode_ff, mode_in;
   logic [1:0]            drive_ff, drive_in;
   logic                  active_ff, active_in;
   logic                  is_close_ff, is_close_in;
   logic [DELAY_BITS-1:0] elapsed_ff, elapsed_in;

   logic [1:0]          req;
   logic [2:0]          pos;
   logic [1:0]          next_mode;
   logic [CMP_BITS-1:0] delay_wide;
   logic [CMP_BITS-1:0] delay_sat;

   always_comb begin
      req = item.requested_state;
      if (req != REQ_OPEN && req != REQ_CLOSED) begin
         req = REQ_OFF;
      end

      // closed sensor wins when both are low
      if (!item.closed_sensor_level) begin
         pos = POS_CLOSED;
      end else if (!item.open_sensor_level) begin
         pos = POS_OPEN;
      end else if (req == REQ_OPEN) begin
         pos = POS_OPENING;
      end else if (req == REQ_CLOSED) begin
         pos = POS_CLOSING;
      end else begin
         pos = POS_OFF;
      end

      if (req == REQ_OPEN && pos != POS_OPEN) begin
         next_mode = MODE_OPENING;
      end else if (req == REQ_CLOSED && pos != POS_CLOSED) begin
         next_mode = MODE_CLOSING;
      end else begin
         next_mode = MODE_OFF;
      end

      mode_in     = mode_ff;
      drive_in    = drive_ff;
      active_in   = active_ff;
      is_close_in = is_close_ff;
      elapsed_in  = elapsed_ff;

      if (next_mode != mode_ff) begin
         mode_in = next_mode;
         if (next_mode == MODE_OPENING) begin
            active_in = 1'b0;
            drive_in  = DRIVE_OPEN;
         end else if (next_mode == MODE_CLOSING) begin
            active_in = 1'b0;
            drive_in  = DRIVE_CLOSE;
         end else if (mode_ff == MODE_OPENING || mode_ff == MODE_CLOSING) begin
            // motion ended: keep the motor running through the overrun
            active_in   = 1'b1;
            is_close_in = (mode_ff == MODE_CLOSING);
            elapsed_in  = '0;
         end else begin
            drive_in = DRIVE_OFF;
         end
      end

      delay_wide = is_close_in ? CMP_BITS'(close_delay) : CMP_BITS'(open_delay);
      delay_sat  = (delay_wide > CMP_BITS'(COUNT_MAX)) ? CMP_BITS'(COUNT_MAX) : delay_wide;

      if (active_in) begin
         if (CMP_BITS'(elapsed_in) >= delay_sat) begin
            active_in = 1'b0;
            drive_in  = DRIVE_OFF;
         end else if (elapsed_in != COUNT_MAX) begin
            elapsed_in = elapsed_in + DELAY_BITS'(1);
         end
      end

      result.motor_drive     = drive_in;
      result.tray_position   = pos;
      result.controller_mode = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_OFF;
         drive_ff    <= DRIVE_OFF;
         active_ff   <= 1'b0;
         is_close_ff <= 1'b0;
         elapsed_ff  <= '0;
      end else if (step) begin
         mode_ff     <= mode_in;
         drive_ff    <= drive_in;
         active_ff   <= active_in;
         is_close_ff <= is_close_in;
         elapsed_ff  <= elapsed_in;
      end
   end

endmodule

FILE: hw/rtl/tray_motor_limit_controller.sv
// ----------------------------------------------------------------------------
// tray_motor_limit_controller
// Limit-switch tray motor control with per-direction overrun timing.
// ----------------------------------------------------------------------------
// Each request transaction is one millisecond tick carrying the two active-low
// limit sensor levels and the requested target; each tick yields exactly one
// response transaction with motor drive, reported position and mode. The block
// takes one tick per clock cycle unless the response side stalls; a response
// passes the input register and then the response register, and the controller
// state updates once per tick. The user must write the overrun delays through
// the csr port only while no tick is in flight; the block does not enforce it.
// A delay above the timer range of DELAY_BITS bits saturates to its maximum.
module tray_motor_limit_controller import tmlc_pkg::*; #(
   parameter int DELAY_BITS = DELAY_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_type                   rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CFG_BITS-1:0]       csr_wdata
);

   logic [CFG_BITS-1:0] open_delay_ff;
   logic [CFG_BITS-1:0] close_delay_ff;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;

   logic    out_free;
   logic    advance;
   rsp_type result;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_delay_ff  <= '0;
         close_delay_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_OPEN_OVERRUN:  open_delay_ff  <= csr_wdata;
            CSR_CLOSE_OVERRUN: close_delay_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // input register: hold while the response side is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   tmlc_core #(
      .DELAY_BITS (DELAY_BITS)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .item        (in_data_ff),
      .open_delay  (open_delay_ff),
      .close_delay (close_delay_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

endmodule

FILE: tb/sv/tray_motor_limit_controller_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tray_motor_limit_controller_tb
// Self-checking bench for the tray motor limit controller. Ticks are sent
// through the req_ handshake with random gaps. The response side stalls at
// random. A tick-by-tick state tracker predicts motor drive, position and
// mode, and each response transaction is compared field by field. Overrun
// delays are rewritten between phases while no tick is in flight.
// ----------------------------------------------------------------------------
module tray_motor_limit_controller_tb;
   import tmlc_pkg::*;

   localparam logic       SENSOR_AT_END  = 1'b0;
   localparam logic       SENSOR_CLEAR   = 1'b1;
   localparam logic [1:0] REQ_UNUSED     = 2'd3;
   localparam int         CYCLE_LIMIT    = 1000000;
   localparam int         RANDOM_PHASES  = 8;
   localparam int         PHASE_TICKS    = 230;
   localparam longint unsigned COUNT_MAX  = (64'd1 << DELAY_BITS_DEFAULT) - 1;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_type                   req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CFG_BITS-1:0]       csr_wdata = '0;

   bit   quiet       = 1'b0;
   logic rest_closed = SENSOR_CLEAR;
   logic rest_open   = SENSOR_CLEAR;
   int   cycle_count = 0;

   // Tracks the controller state tick by tick and holds the expected reports.
   class tray_report_board;
      logic [CFG_BITS-1:0]           open_delay;
      logic [CFG_BITS-1:0]           close_delay;
      logic [1:0]                    mode;
      logic [1:0]                    drive;
      bit                            overrun_on;
      bit                            overrun_closing;
      logic [DELAY_BITS_DEFAULT-1:0] overrun_count;
      rsp_type                       expected_reports[$];
      int unsigned                   failures;

      function new();
         open_delay      = '0;
         close_delay     = '0;
         mode            = MODE_OFF;
         drive           = DRIVE_OFF;
         overrun_on      = 1'b0;
         overrun_closing = 1'b0;
         overrun_count   = '0;
         failures        = 0;
      endfunction

      function void set_delay(logic [CSR_INDEX_BITS-1:0] idx, logic [CFG_BITS-1:0] value);
         if (idx == CSR_OPEN_OVERRUN) begin
            open_delay = value;
         end else begin
            close_delay = value;
         end
      endfunction

      function void note_tick(req_type t);
         logic [1:0]        want;
         logic [2:0]        pos;
         logic [1:0]        next_mode;
         logic [1:0]        prev_mode;
         longint unsigned   limit;
         rsp_type           report;
         want = t.requested_state;
         if (want != REQ_OPEN && want != REQ_CLOSED) begin
            want = REQ_OFF;
         end
         // closed sensor wins when both read at end
         if (t.closed_sensor_level == SENSOR_AT_END) begin
            pos = POS_CLOSED;
         end else if (t.open_sensor_level == SENSOR_AT_END) begin
            pos = POS_OPEN;
         end else if (want == REQ_OPEN) begin
            pos = POS_OPENING;
         end else if (want == REQ_CLOSED) begin
            pos = POS_CLOSING;
         end else begin
            pos = POS_OFF;
         end
         if (want == REQ_OPEN && pos != POS_OPEN) begin
            next_mode = MODE_OPENING;
         end else if (want == REQ_CLOSED && pos != POS_CLOSED) begin
            next_mode = MODE_CLOSING;
         end else begin
            next_mode = MODE_OFF;
         end
         if (next_mode != mode) begin
            prev_mode = mode;
            mode = next_mode;
            if (next_mode == MODE_OPENING) begin
               overrun_on = 1'b0;
               drive = DRIVE_OPEN;
            end else if (next_mode == MODE_CLOSING) begin
               overrun_on = 1'b0;
               drive = DRIVE_CLOSE;
            end else if (prev_mode == MODE_OPENING || prev_mode == MODE_CLOSING) begin
               // keep the motor running, start the overrun for that direction
               overrun_on = 1'b1;
               overrun_closing = (prev_mode == MODE_CLOSING);
               overrun_count = '0;
            end else begin
               drive = DRIVE_OFF;
            end
         end
         if (overrun_on) begin
            limit = 64'(overrun_closing ? close_delay : open_delay);
            if (limit > COUNT_MAX) begin
               limit = COUNT_MAX;
            end
            if (overrun_count >= limit) begin
               overrun_on = 1'b0;
               drive = DRIVE_OFF;
            end else if (overrun_count < COUNT_MAX) begin
               overrun_count = overrun_count + DELAY_BITS_DEFAULT'(1);
            end
         end
         report.motor_drive     = drive;
         report.tray_position   = pos;
         report.controller_mode = mode;
         expected_reports.push_back(report);
      endfunction

      function void check_report(rsp_type got);
         rsp_type want;
         if (expected_reports.size() == 0) begin
            $error("response transaction with no tick outstanding: %p", got);
            failures++;
            return;
         end
         want = expected_reports.pop_front();
         if (got.motor_drive !== want.motor_drive) begin
            $error("motor_drive: expected %0d, got %0d", want.motor_drive, got.motor_drive);
            failures++;
         end
         if (got.tray_position !== want.tray_position) begin
            $error("tray_position: expected %0d, got %0d",
                   want.tray_position, got.tray_position);
            failures++;
         end
         if (got.controller_mode !== want.controller_mode) begin
            $error("controller_mode: expected %0d, got %0d",
                   want.controller_mode, got.controller_mode);
            failures++;
         end
      endfunction
   endclass

   tray_report_board board = new();

   tray_motor_limit_controller u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Note accepted ticks first, then check any response transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_tick(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            board.check_report(rsp_data);
         end
      end
   end

   // Mostly short gaps, a few long ones, none while quiet.
   function automatic int pick_gap();
      int roll;
      if (quiet) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 60) begin
         return 0;
      end else if (roll < 88) begin
         return $urandom_range(1, 3);
      end else if (roll < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   initial begin : response_stall
      int gap;
      wait (!reset);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   task automatic send_tick(input logic closed_lvl, input logic open_lvl,
                            input logic [1:0] want);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{closed_sensor_level: closed_lvl, open_sensor_level: open_lvl,
                     requested_state: want};
      do @(posedge clock); while (!req_ready);
   endtask

   // Drain every outstanding tick, then write both overrun delays.
   task automatic write_overruns(input logic [CFG_BITS-1:0] open_value,
                                 input logic [CFG_BITS-1:0] close_value);
      req_valid <= 1'b0;
      // let the last accepted tick be noted before judging the drain
      @(posedge clock);
      while (board.expected_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_OPEN_OVERRUN;
      csr_wdata <= open_value;
      @(posedge clock);
      board.set_delay(CSR_OPEN_OVERRUN, open_value);
      csr_index <= CSR_CLOSE_OVERRUN;
      csr_wdata <= close_value;
      @(posedge clock);
      board.set_delay(CSR_CLOSE_OVERRUN, close_value);
      csr_we <= 1'b0;
   endtask

   // Runs of one request; motions may end on their limit sensor, which then
   // stays at end until the tray moves away. A few ticks get noisy sensors.
   task automatic random_ticks(input int count);
      int         left;
      int         run_len;
      int         roll;
      bit         motion;
      logic [1:0] want;
      logic       closed_lvl;
      logic       open_lvl;
      left = count;
      while (left > 0) begin
         roll = $urandom_range(0, 99);
         want = (roll < 38) ? REQ_OPEN : (roll < 76) ? REQ_CLOSED :
                (roll < 92) ? REQ_OFF : REQ_UNUSED;
         motion = (want == REQ_OPEN || want == REQ_CLOSED);
         run_len = $urandom_range(1, 40);
         if (run_len > left) begin
            run_len = left;
         end
         for (int k = 0; k < run_len; k++) begin
            closed_lvl = rest_closed;
            open_lvl   = rest_open;
            if (motion && k > 0) begin
               rest_closed = SENSOR_CLEAR;
               rest_open   = SENSOR_CLEAR;
               closed_lvl  = SENSOR_CLEAR;
               open_lvl    = SENSOR_CLEAR;
               if (k == run_len - 1 && $urandom_range(0, 9) < 7) begin
                  if (want == REQ_OPEN) begin
                     rest_open = SENSOR_AT_END;
                     open_lvl  = SENSOR_AT_END;
                  end else begin
                     rest_closed = SENSOR_AT_END;
                     closed_lvl  = SENSOR_AT_END;
                  end
               end
            end
            if ($urandom_range(0, 99) < 6) begin
               {closed_lvl, open_lvl} = 2'($urandom_range(0, 3));
            end
            send_tick(closed_lvl, open_lvl, want);
         end
         left -= run_len;
      end
   endtask

   initial begin : stimulus
      logic [CFG_BITS-1:0] open_value;
      logic [CFG_BITS-1:0] close_value;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero delays after reset: motor stops on the tick a motion ends
      send_tick(SENSOR_CLEAR,  SENSOR_CLEAR,  REQ_OFF);
      send_tick(SENSOR_CLEAR,  SENSOR_CLEAR,  REQ_OPEN);
      send_tick(SENSOR_CLEAR,  SENSOR_CLEAR,  REQ_OPEN);
      send_tick(SENSOR_CLEAR,  SENSOR_AT_END, REQ_OPEN);
      send_tick(SENSOR_CLEAR,  SENSOR_CLEAR,  REQ_CLOSED);
      send_tick(SENSOR_CLEAR,  SENSOR_CLEAR,  REQ_OPEN);
      send_tick(SENSOR_CLEAR,  SENSOR_CLEAR,  REQ_CLOSED);
      send_tick(SENSOR_AT_END, SENSOR_CLEAR,  REQ_CLOSED);
      send_tick(SENSOR_AT_END, SENSOR_AT_END, REQ_OPEN);
      send_tick(SENSOR_AT_END, SENSOR_AT_END, REQ_OFF);
      send_tick(SENSOR_CLEAR,  SENSOR_AT_END, REQ_CLOSED);
      send_tick(SENSOR_AT_END, SENSOR_CLEAR,  REQ_OPEN);
      send_tick(SENSOR_CLEAR,  SENSOR_CLEAR,  REQ_UNUSED);
      send_tick(SENSOR_AT_END, SENSOR_AT_END, REQ_UNUSED);
      send_tick(SENSOR_CLEAR,  SENSOR_AT_END, REQ_OFF);
      send_tick(SENSOR_AT_END, SENSOR_CLEAR,  REQ_OFF);

      // short open overrun expires, longest close overrun is cut by a new motion
      write_overruns(16'd2, 16'hFFFF);
      send_tick(SENSOR_CLEAR, SENSOR_CLEAR, REQ_OPEN);
      repeat (3) send_tick(SENSOR_CLEAR, SENSOR_CLEAR, REQ_OFF);
      send_tick(SENSOR_CLEAR, SENSOR_CLEAR, REQ_CLOSED);
      repeat (2) send_tick(SENSOR_CLEAR, SENSOR_CLEAR, REQ_OFF);
      send_tick(SENSOR_CLEAR, SENSOR_CLEAR, REQ_OPEN);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin open_value = '0;    close_value = '0;    end
            1: begin open_value = '1;    close_value = '1;    end
            2: begin open_value = 16'd1; close_value = '0;    end
            3: begin open_value = '0;    close_value = 16'd1; end
            default: begin
               open_value  = 16'($urandom_range(0, 30));
               close_value = 16'($urandom_range(0, 30));
            end
         endcase
         quiet = (p == 3 || p == 6);
         write_overruns(open_value, close_value);
         random_ticks(PHASE_TICKS);
      end

      req_valid <= 1'b0;
      quiet = 1'b0;
      @(posedge clock);
      while (board.expected_reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.failures == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/tmlc_pkg.sv
hw/rtl/tmlc_core.sv
hw/rtl/tray_motor_limit_controller.sv
tb/sv/tray_motor_limit_controller_tb.sv
